FILE: rtl/sms_pkg.sv
// Shared types, codes and constants for the shutter motor sequencer.
package sms_pkg;

  localparam int unsigned CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

  localparam logic [CNT_W-1:0] HOLD_SHORT_RST = 10'd15;
  localparam logic [CNT_W-1:0] MAX_RUN_RST    = 10'd300;
  localparam logic [CNT_W-1:0] COOLDOWN_RST   = 10'd5;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_HOLD_SHORT = 2'd0,
    REG_MAX_RUN    = 2'd1,
    REG_COOLDOWN   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_UP       = 3'd1,
    MODE_DOWN     = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_STOP_ALL = 3'd4,
    MODE_SHORT    = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    ST_REST           = 4'd0,
    ST_STOP           = 4'd1,
    ST_STOP2          = 4'd2,
    ST_PREP_UP        = 4'd3,
    ST_PREP_DOWN      = 4'd4,
    ST_START_UP       = 4'd5,
    ST_START_DOWN     = 4'd6,
    ST_COOL_FROM_DOWN = 4'd7,
    ST_COOL_FROM_UP   = 4'd8,
    ST_WAIT_TO_UP     = 4'd9,
    ST_WAIT_TO_DOWN   = 4'd10,
    ST_UP             = 4'd11,
    ST_DOWN           = 4'd12
  } shst_t;

  typedef enum logic {
    CTL_EMPTY = 1'b0,
    CTL_FULL  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] hold_short_limit;
    logic [CNT_W-1:0] max_run_time;
    logic [CNT_W-1:0] cooldown_time;
  } cfg_t;

  typedef struct packed {
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } ctl_status_t;

  localparam logic signed [1:0] STATUS_UP   = 2'sd1;
  localparam logic signed [1:0] STATUS_DOWN = -2'sd1;
  localparam logic signed [1:0] STATUS_REST = 2'sd0;

  function automatic logic signed [1:0] move_status_of(input shst_t st);
    logic signed [1:0] res;
    unique case (st)
      ST_PREP_UP, ST_START_UP, ST_UP, ST_COOL_FROM_DOWN, ST_WAIT_TO_UP:
        res = STATUS_UP;
      ST_PREP_DOWN, ST_START_DOWN, ST_DOWN, ST_COOL_FROM_UP, ST_WAIT_TO_DOWN:
        res = STATUS_DOWN;
      default:
        res = STATUS_REST;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/sms_in_if.sv
// Command channel: mode and shutter index with valid/ready.
interface sms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] shutter_index;

  modport source (output valid, output mode, output shutter_index, input ready);
  modport sink   (input valid, input mode, input shutter_index, output ready);
endinterface

FILE: rtl/sms_out_if.sv
// Result channel: relay and status report with valid/ready.
interface sms_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        shutter_id;
  logic              motor_on;
  logic              direction_up;
  logic signed [1:0] move_status;
  logic              rejected;

  modport source (output valid, output shutter_id, output motor_on, output direction_up,
                  output move_status, output rejected, input ready);
  modport sink   (input valid, input shutter_id, input motor_on, input direction_up,
                  input move_status, input rejected, output ready);
endinterface

FILE: rtl/sms_cfg.sv
// APB register block holding the sequencer timing limits.
module sms_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sms_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output sms_pkg::cfg_t                 cfg
);
  import sms_pkg::*;

  logic     wr_en;
  cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_short_limit <= HOLD_SHORT_RST;
      cfg.max_run_time     <= MAX_RUN_RST;
      cfg.cooldown_time    <= COOLDOWN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HOLD_SHORT: cfg.hold_short_limit <= pwdata[CNT_W-1:0];
        REG_MAX_RUN:    cfg.max_run_time     <= pwdata[CNT_W-1:0];
        REG_COOLDOWN:   cfg.cooldown_time    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HOLD_SHORT: prdata = {22'd0, cfg.hold_short_limit};
      REG_MAX_RUN:    prdata = {22'd0, cfg.max_run_time};
      REG_COOLDOWN:   prdata = {22'd0, cfg.cooldown_time};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/sms_ctrl.sv
// Handshake controller tracking occupancy of the result register.
module sms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  sms_pkg::ctl_status_t status,
  output logic                 in_ready,
  output logic                 out_valid,
  output sms_pkg::dp_cmd_t     cmd
);
  import sms_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      CTL_EMPTY: state_next = status.in_valid ? CTL_FULL : CTL_EMPTY;
      CTL_FULL:  state_next = (status.out_ready && !status.in_valid) ? CTL_EMPTY : CTL_FULL;
      default:   state_next = CTL_EMPTY;
    endcase
  end

  always_comb begin
    unique case (state)
      CTL_EMPTY: begin
        in_ready  = 1'b1;
        out_valid = 1'b0;
      end
      CTL_FULL: begin
        in_ready  = status.out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.commit = status.in_valid && in_ready;
  end

endmodule

FILE: rtl/sms_datapath.sv
// Per-shutter state, run counters, relays and the result register.
module sms_datapath #(
  parameter int unsigned NUM_SHUTTERS = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sms_pkg::dp_cmd_t         cmd,
  input  sms_pkg::cfg_t            cfg,
  input  logic [2:0]               mode,
  input  logic [3:0]               shutter_index,
  output logic [3:0]               shutter_id,
  output logic                     motor_on,
  output logic                     direction_up,
  output logic signed [1:0]        move_status,
  output logic                     rejected
);
  import sms_pkg::*;

  localparam int unsigned IW = (NUM_SHUTTERS > 1) ? $clog2(NUM_SHUTTERS) : 1;
  localparam logic [4:0]  NUM_W = 5'(NUM_SHUTTERS);

  shst_t            st  [NUM_SHUTTERS];
  logic [CNT_W-1:0] cnt [NUM_SHUTTERS];
  logic             mot [NUM_SHUTTERS];
  logic             dir [NUM_SHUTTERS];

  logic             in_range;
  logic             stop_all;
  logic [IW-1:0]    sel;
  shst_t            cur_st, tick_st, st_next;
  logic [CNT_W-1:0] cur_cnt, tick_cnt, cnt_next;
  logic             cur_mot, mot_next, cur_dir, dir_next;

  assign in_range = {1'b0, shutter_index} < NUM_W;
  assign stop_all = mode_t'(mode) == MODE_STOP_ALL;
  assign sel      = in_range ? shutter_index[IW-1:0] : '0;
  assign cur_st   = st[sel];
  assign cur_cnt  = cnt[sel];
  assign cur_mot  = mot[sel];
  assign cur_dir  = dir[sel];

  always_comb begin
    tick_cnt = (cur_st != ST_REST && cur_cnt != CNT_MAX) ? cur_cnt + 10'd1 : cur_cnt;
    tick_st  = (tick_cnt > cfg.max_run_time) ? ST_STOP : cur_st;
    st_next  = cur_st;
    cnt_next = cur_cnt;
    mot_next = cur_mot;
    dir_next = cur_dir;
    unique case (mode_t'(mode))
      MODE_TICK: begin
        st_next  = tick_st;
        cnt_next = tick_cnt;
        unique case (tick_st)
          ST_STOP: begin
            mot_next = 1'b0;
            cnt_next = '0;
            st_next  = ST_STOP2;
          end
          ST_STOP2: begin
            dir_next = 1'b0;
            st_next  = ST_REST;
          end
          ST_PREP_UP: begin
            dir_next = 1'b1;
            st_next  = ST_START_UP;
          end
          ST_PREP_DOWN: begin
            dir_next = 1'b0;
            st_next  = ST_START_DOWN;
          end
          ST_START_UP: begin
            mot_next = 1'b1;
            cnt_next = '0;
            st_next  = ST_UP;
          end
          ST_START_DOWN: begin
            mot_next = 1'b1;
            cnt_next = '0;
            st_next  = ST_DOWN;
          end
          ST_COOL_FROM_DOWN: begin
            mot_next = 1'b0;
            cnt_next = '0;
            st_next  = ST_WAIT_TO_UP;
          end
          ST_COOL_FROM_UP: begin
            mot_next = 1'b0;
            cnt_next = '0;
            st_next  = ST_WAIT_TO_DOWN;
          end
          ST_WAIT_TO_UP: begin
            if (tick_cnt > cfg.cooldown_time) st_next = ST_PREP_UP;
          end
          ST_WAIT_TO_DOWN: begin
            if (tick_cnt > cfg.cooldown_time) st_next = ST_PREP_DOWN;
          end
          default: ;
        endcase
      end
      MODE_UP: begin
        unique case (cur_st)
          ST_REST: st_next = ST_PREP_UP;
          ST_DOWN: st_next = ST_COOL_FROM_DOWN;
          ST_UP:   st_next = ST_STOP;
          default: ;
        endcase
      end
      MODE_DOWN: begin
        unique case (cur_st)
          ST_REST: st_next = ST_PREP_DOWN;
          ST_UP:   st_next = ST_COOL_FROM_UP;
          ST_DOWN: st_next = ST_STOP;
          default: ;
        endcase
      end
      MODE_STOP:     st_next = ST_STOP;
      MODE_STOP_ALL: st_next = ST_STOP;
      MODE_SHORT: begin
        if (cur_cnt < cfg.hold_short_limit) st_next = ST_STOP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SHUTTERS; i++) begin
      if (rst) begin
        st[i]  <= ST_REST;
        cnt[i] <= '0;
        mot[i] <= 1'b0;
        dir[i] <= 1'b0;
      end else if (cmd.commit) begin
        if (stop_all) begin
          st[i] <= ST_STOP;
        end else if (in_range && sel == IW'(i)) begin
          st[i]  <= st_next;
          cnt[i] <= cnt_next;
          mot[i] <= mot_next;
          dir[i] <= dir_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      shutter_id   <= shutter_index;
      rejected     <= !in_range && !stop_all;
      motor_on     <= in_range && mot_next;
      direction_up <= in_range && dir_next;
      move_status  <= in_range ? move_status_of(st_next) : STATUS_REST;
    end
  end

endmodule

FILE: rtl/shutter_motor_sequencer.sv
// Shutter motor sequencer top level: controller, datapath and registers.
// The result is valid in the cycle after the command transfer.
// Throughput: one command per cycle while the result is taken; the result register frees as it is taken.
// Per-shutter state update is a read-modify-write of register-held state, written back on command transfer.
// Reset (rst, synchronous): all shutters at rest, counters zero, relays off and down,
// limits back to 15 / 300 / 5, result register empty.
module shutter_motor_sequencer #(
  parameter int unsigned NUM_SHUTTERS = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  sms_in_if.sink                      in_ch,
  sms_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sms_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sms_pkg::*;

  cfg_t        cfg;
  dp_cmd_t     cmd;
  ctl_status_t status;

  assign status.in_valid  = in_ch.valid;
  assign status.out_ready = out_ch.ready;

  sms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  sms_datapath #(
    .NUM_SHUTTERS (NUM_SHUTTERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .mode          (in_ch.mode),
    .shutter_index (in_ch.shutter_index),
    .shutter_id    (out_ch.shutter_id),
    .motor_on      (out_ch.motor_on),
    .direction_up  (out_ch.direction_up),
    .move_status   (out_ch.move_status),
    .rejected      (out_ch.rejected)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> out_ch.valid)
    else $error("accepted command produced no result");

  a_stop_all_not_rejected: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.mode == MODE_STOP_ALL |=> !out_ch.rejected)
    else $error("stop-all result flagged as rejected");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.rejected |->
      !out_ch.motor_on && !out_ch.direction_up && out_ch.move_status == STATUS_REST)
    else $error("rejected result carries relay state");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.move_status != 2'sb10)
    else $error("illegal move status code");

endmodule
